@@ sv/bttm_pkg.sv @@
package bttm_pkg;

   // Block averaging
   localparam int SamplesPerAverage = 32;
   localparam int AvgShift          = $clog2(SamplesPerAverage);
   localparam int SumWidth          = 16 + AvgShift;
   localparam int CountWidth        = $clog2(SamplesPerAverage + 1);

   // Battery gain is Q4.12
   localparam int GainFracBits = 12;
   localparam int ProdWidth    = 32;

   // Register indexes on the config port
   localparam int CsrIndexWidth = 3;
   localparam logic [CsrIndexWidth-1:0] CSR_SYNC_RATE      = 3'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_WARNING_RATE   = 3'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_VOLT_GAIN      = 3'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_BATTERY_LIMIT  = 3'd3;
   localparam logic [CsrIndexWidth-1:0] CSR_TEMP_LIMIT     = 3'd4;
   localparam logic [CsrIndexWidth-1:0] CSR_WARNING_ENABLE = 3'd5;

   // Register reset values
   localparam logic [15:0]        SYNC_RATE_RESET      = 16'd1;
   localparam logic [15:0]        WARNING_RATE_RESET   = 16'd50;
   localparam logic [15:0]        VOLT_GAIN_RESET      = 16'd4096;
   localparam logic [15:0]        BATTERY_LIMIT_RESET  = 16'd5632;
   localparam logic signed [15:0] TEMP_LIMIT_RESET     = 16'sd16640;
   localparam logic               WARNING_ENABLE_RESET = 1'b1;

   localparam logic [15:0] COUNT_MAX = 16'hFFFF;

   typedef struct packed {
      logic [15:0]        sync_rate;
      logic [15:0]        warning_rate;
      logic [15:0]        volt_gain;
      logic [15:0]        battery_limit;
      logic signed [15:0] temp_limit;
      logic               warning_enable;
   } cfg_type;

   // One tick after battery scaling
   typedef struct packed {
      logic               data_ready;
      logic [15:0]        battery_scaled;
      logic signed [15:0] temp_sample;
   } sample_type;

   typedef struct packed {
      logic               monitor_step;
      logic               battery_low;
      logic               temp_high;
      logic [15:0]        battery_level;
      logic signed [15:0] temperature;
      logic               buzzer_on;
      logic               switch_control;
   } result_type;

endpackage

@@ sv/bttm_ifs.sv @@
interface bttm_req_if;
   logic               valid;
   logic               ready;
   logic               data_ready;
   logic [15:0]        battery_sample;
   logic signed [15:0] temp_sample;

   modport source (output valid, data_ready, battery_sample, temp_sample, input ready);
   modport sink   (input valid, data_ready, battery_sample, temp_sample, output ready);
endinterface

interface bttm_rsp_if;
   logic               valid;
   logic               ready;
   logic               monitor_step;
   logic               battery_low;
   logic               temp_high;
   logic [15:0]        battery_level;
   logic signed [15:0] temperature;
   logic               buzzer_on;
   logic               switch_control;

   modport source (output valid, monitor_step, battery_low, temp_high, battery_level,
                   temperature, buzzer_on, switch_control, input ready);
   modport sink   (input valid, monitor_step, battery_low, temp_high, battery_level,
                   temperature, buzzer_on, switch_control, output ready);
endinterface

interface bttm_csr_if;
   logic                                 valid;
   logic                                 ready;
   logic [bttm_pkg::CsrIndexWidth-1:0]   index;
   logic [15:0]                          data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

@@ sv/bttm_csr.sv @@
module bttm_csr (
   input  logic              clock,
   input  logic              reset,
   bttm_csr_if.sink          csr_bus,
   output bttm_pkg::cfg_type cfg
);

   bttm_pkg::cfg_type cfg_ff;
   bttm_pkg::cfg_type cfg_in;

   // writes are always accepted and registered
   assign csr_bus.ready = 1'b1;

   // register decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_bus.valid) begin
         unique case (csr_bus.index)
            bttm_pkg::CSR_SYNC_RATE:      cfg_in.sync_rate      = csr_bus.data;
            bttm_pkg::CSR_WARNING_RATE:   cfg_in.warning_rate   = csr_bus.data;
            bttm_pkg::CSR_VOLT_GAIN:      cfg_in.volt_gain      = csr_bus.data;
            bttm_pkg::CSR_BATTERY_LIMIT:  cfg_in.battery_limit  = csr_bus.data;
            bttm_pkg::CSR_TEMP_LIMIT:     cfg_in.temp_limit     = csr_bus.data;
            bttm_pkg::CSR_WARNING_ENABLE: cfg_in.warning_enable = csr_bus.data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sync_rate      <= bttm_pkg::SYNC_RATE_RESET;
         cfg_ff.warning_rate   <= bttm_pkg::WARNING_RATE_RESET;
         cfg_ff.volt_gain      <= bttm_pkg::VOLT_GAIN_RESET;
         cfg_ff.battery_limit  <= bttm_pkg::BATTERY_LIMIT_RESET;
         cfg_ff.temp_limit     <= bttm_pkg::TEMP_LIMIT_RESET;
         cfg_ff.warning_enable <= bttm_pkg::WARNING_ENABLE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ sv/bttm_scale.sv @@
module bttm_scale (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [15:0]          volt_gain,
   bttm_req_if.sink             req_bus,
   output logic                 out_valid,
   input  logic                 out_ready,
   output bttm_pkg::sample_type out_sample
);

   logic               in_valid_ff;
   logic               in_valid_in;
   logic               in_ready_ff_side;
   logic               in_data_ready_ff;
   logic [15:0]        in_battery_ff;
   logic signed [15:0] in_temp_ff;

   logic                 mid_valid_ff;
   logic                 mid_valid_in;
   bttm_pkg::sample_type mid_sample_ff;
   bttm_pkg::sample_type mid_sample_in;

   logic                                      mid_ready;
   logic [bttm_pkg::ProdWidth-1:0]            product;
   logic [bttm_pkg::ProdWidth-bttm_pkg::GainFracBits-1:0] shifted;

   // stage handshakes: a stage loads when it is empty or draining
   assign mid_ready        = !mid_valid_ff || out_ready;
   assign in_ready_ff_side = !in_valid_ff || mid_ready;
   assign req_bus.ready    = in_ready_ff_side;

   assign in_valid_in  = req_bus.valid || (in_valid_ff && !mid_ready);
   assign mid_valid_in = in_valid_ff || (mid_valid_ff && !out_ready);

   // gain multiply, drop fraction, saturate to 16 bits
   always_comb begin
      product  = in_battery_ff * volt_gain;
      shifted  = product[bttm_pkg::ProdWidth-1:bttm_pkg::GainFracBits];
      mid_sample_in.data_ready  = in_data_ready_ff;
      mid_sample_in.temp_sample = in_temp_ff;
      if (|shifted[$bits(shifted)-1:16]) begin
         mid_sample_in.battery_scaled = 16'hFFFF;
      end else begin
         mid_sample_in.battery_scaled = shifted[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         mid_valid_ff <= 1'b0;
      end else begin
         if (in_ready_ff_side) begin
            in_valid_ff <= in_valid_in;
         end
         if (mid_ready) begin
            mid_valid_ff <= mid_valid_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (in_ready_ff_side && req_bus.valid) begin
         in_data_ready_ff <= req_bus.data_ready;
         in_battery_ff    <= req_bus.battery_sample;
         in_temp_ff       <= req_bus.temp_sample;
      end
      if (mid_ready && in_valid_ff) begin
         mid_sample_ff <= mid_sample_in;
      end
   end

   assign out_valid  = mid_valid_ff;
   assign out_sample = mid_sample_ff;

endmodule

@@ sv/bttm_core.sv @@
module bttm_core (
   input  logic                 clock,
   input  logic                 reset,
   input  bttm_pkg::cfg_type    cfg,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  bttm_pkg::sample_type in_sample,
   output logic                 out_valid,
   input  logic                 out_ready,
   output bttm_pkg::result_type out_result
);

   logic [15:0]                         tick_ff, tick_in;
   logic [15:0]                         warn_ff, warn_in;
   logic [bttm_pkg::CountWidth-1:0]     count_ff, count_in;
   logic [bttm_pkg::SumWidth-1:0]       bat_sum_ff, bat_sum_in;
   logic signed [bttm_pkg::SumWidth-1:0] temp_sum_ff, temp_sum_in;
   logic [15:0]                         bat_avg_ff, bat_avg_in;
   logic signed [15:0]                  temp_avg_ff, temp_avg_in;
   logic                                low_ff, low_in;
   logic                                hot_ff, hot_in;
   logic                                buzzer_ff, buzzer_in;
   logic                                out_valid_ff;
   bttm_pkg::result_type                result_ff, result_in;

   logic [15:0]                          tick_inc, warn_inc;
   logic                                 step;
   logic                                 handed;
   logic [bttm_pkg::CountWidth-1:0]      count_next;
   logic [bttm_pkg::SumWidth-1:0]        bat_sum_next;
   logic signed [bttm_pkg::SumWidth-1:0] temp_sum_next;
   logic                                 accept;

   assign in_ready = !out_valid_ff || out_ready;
   assign accept   = in_valid && in_ready;

   // monitor step: prescaler, averaging, flags, buzzer divider
   always_comb begin
      tick_in     = tick_ff;
      warn_in     = warn_ff;
      count_in    = count_ff;
      bat_sum_in  = bat_sum_ff;
      temp_sum_in = temp_sum_ff;
      bat_avg_in  = bat_avg_ff;
      temp_avg_in = temp_avg_ff;
      low_in      = low_ff;
      hot_in      = hot_ff;
      buzzer_in   = buzzer_ff;
      handed      = 1'b0;

      tick_inc = (tick_ff == bttm_pkg::COUNT_MAX) ? tick_ff : tick_ff + 16'd1;
      warn_inc = (warn_ff == bttm_pkg::COUNT_MAX) ? warn_ff : warn_ff + 16'd1;
      step     = tick_inc >= cfg.sync_rate;

      count_next    = count_ff + bttm_pkg::CountWidth'(1);
      bat_sum_next  = bat_sum_ff + {{(bttm_pkg::SumWidth-16){1'b0}},
                                    in_sample.battery_scaled};
      temp_sum_next = temp_sum_ff + {{(bttm_pkg::SumWidth-16){in_sample.temp_sample[15]}},
                                     in_sample.temp_sample};

      if (step) begin
         tick_in = 16'd0;
         warn_in = warn_inc;

         // accumulate, and close the block when full
         if (in_sample.data_ready) begin
            if (count_next >= bttm_pkg::CountWidth'(bttm_pkg::SamplesPerAverage)) begin
               bat_avg_in  = bat_sum_next[bttm_pkg::AvgShift +: 16];
               temp_avg_in = temp_sum_next[bttm_pkg::AvgShift +: 16];
               low_in      = bat_sum_next[bttm_pkg::AvgShift +: 16] <= cfg.battery_limit;
               hot_in      = $signed(temp_sum_next[bttm_pkg::AvgShift +: 16])
                             >= cfg.temp_limit;
               count_in    = '0;
               bat_sum_in  = '0;
               temp_sum_in = '0;
            end else begin
               count_in    = count_next;
               bat_sum_in  = bat_sum_next;
               temp_sum_in = temp_sum_next;
            end
         end

         // buzzer divider
         if (cfg.warning_enable) begin
            if (warn_inc >= cfg.warning_rate) begin
               warn_in   = 16'd0;
               buzzer_in = (low_in || hot_in) ? !buzzer_ff : 1'b0;
            end
            handed = !low_in && !hot_in;
         end else begin
            handed = 1'b1;
         end
      end else begin
         tick_in = tick_inc;
      end

      result_in.monitor_step    = step;
      result_in.battery_low     = low_in;
      result_in.temp_high       = hot_in;
      result_in.battery_level   = bat_avg_in;
      result_in.temperature     = temp_avg_in;
      result_in.buzzer_on       = buzzer_in;
      result_in.switch_control  = handed;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff      <= '0;
         warn_ff      <= '0;
         count_ff     <= '0;
         bat_sum_ff   <= '0;
         temp_sum_ff  <= '0;
         bat_avg_ff   <= '0;
         temp_avg_ff  <= '0;
         low_ff       <= 1'b0;
         hot_ff       <= 1'b0;
         buzzer_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            tick_ff     <= tick_in;
            warn_ff     <= warn_in;
            count_ff    <= count_in;
            bat_sum_ff  <= bat_sum_in;
            temp_sum_ff <= temp_sum_in;
            bat_avg_ff  <= bat_avg_in;
            temp_avg_ff <= temp_avg_in;
            low_ff      <= low_in;
            hot_ff      <= hot_in;
            buzzer_ff   <= buzzer_in;
         end
         if (in_ready) begin
            out_valid_ff <= in_valid;
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (accept) begin
         result_ff <= result_in;
      end
   end

   assign out_valid  = out_valid_ff;
   assign out_result = result_ff;

endmodule

@@ sv/battery_temp_threshold_monitor.sv @@
// Battery and temperature threshold monitor.
//
// req_bus carries one main-loop tick per request: data_ready, the raw battery
// sample and the temperature sample. rsp_bus returns exactly one result per
// request, in order: whether the monitor step ran, the low-battery and
// over-temperature flags, the current averages, the buzzer level and the
// switch-control handoff. csr_bus writes the six settings registers and is
// always ready; write them only while no request is in flight.
//
// A request passes through three registers on its way to rsp_bus.valid: the
// input register, the battery gain multiplier stage, and the state update into
// the result register. Throughput is one request per cycle while rsp_bus.ready
// is high; the state update of prescaler, sums and buzzer divider keeps pace.
//
// Reset (synchronous, active high) loads the register defaults and clears
// counters, sums, averages, flags and the buzzer. When the receiver stalls,
// the result holds and the stages behind it fill, after which req_bus.ready
// drops; no request is lost or repeated.
module battery_temp_threshold_monitor (
   input  logic       clock,
   input  logic       reset,
   bttm_req_if.sink   req_bus,
   bttm_rsp_if.source rsp_bus,
   bttm_csr_if.sink   csr_bus
);

   bttm_pkg::cfg_type    cfg;
   logic                 smp_valid;
   logic                 smp_ready;
   bttm_pkg::sample_type smp;
   bttm_pkg::result_type result;

   bttm_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .cfg     (cfg)
   );

   bttm_scale u_scale (
      .clock      (clock),
      .reset      (reset),
      .volt_gain  (cfg.volt_gain),
      .req_bus    (req_bus),
      .out_valid  (smp_valid),
      .out_ready  (smp_ready),
      .out_sample (smp)
   );

   bttm_core u_core (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .in_valid   (smp_valid),
      .in_ready   (smp_ready),
      .in_sample  (smp),
      .out_valid  (rsp_bus.valid),
      .out_ready  (rsp_bus.ready),
      .out_result (result)
   );

   // response payload
   assign rsp_bus.monitor_step    = result.monitor_step;
   assign rsp_bus.battery_low     = result.battery_low;
   assign rsp_bus.temp_high       = result.temp_high;
   assign rsp_bus.battery_level   = result.battery_level;
   assign rsp_bus.temperature     = result.temperature;
   assign rsp_bus.buzzer_on       = result.buzzer_on;
   assign rsp_bus.switch_control  = result.switch_control;

endmodule

@@ sv/bttm_checker.sv @@
module bttm_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic               monitor_step,
   input logic               switch_control,
   input logic               buzzer_on,
   input logic [15:0]        battery_level,
   input logic signed [15:0] temperature
);

   // nothing comes out right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // handoff to switch control only happens on a monitor step
   a_handoff_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!switch_control || monitor_step))
      else $error("switch control without a monitor step");

   // a stalled response keeps its buzzer, level, temperature and step fields
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(buzzer_on)
         && $stable(battery_level) && $stable(temperature) && $stable(monitor_step))
      else $error("stalled response changed");

endmodule

bind battery_temp_threshold_monitor bttm_checker u_bttm_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .monitor_step    (rsp_bus.monitor_step),
   .switch_control  (rsp_bus.switch_control),
   .buzzer_on       (rsp_bus.buzzer_on),
   .battery_level   (rsp_bus.battery_level),
   .temperature     (rsp_bus.temperature)
);
